/* rtl/sckq_pkg.sv */
// Shared types, codes and keycode tables for the scancode event queue.
`default_nettype none
package sckq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int CODE_W          = 7;
  localparam int TIME_W          = 64;
  localparam int EVT_PEND_W      = 7;

  // request codes on the input beat
  localparam logic [1:0] REQ_KEY   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  // commands from the front end to the queue engine
  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_KEY   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CODE_W-1:0] scancode;
    logic              extended;
    logic              released;
    logic [TIME_W-1:0] time_ns;
  } in_t;

  typedef struct packed {
    logic                  event_valid;
    logic                  event_type;
    logic [CODE_W-1:0]     event_code;
    logic                  event_value;
    logic [TIME_W-1:0]     event_time_ns;
    logic [EVT_PEND_W-1:0] events_pending;
    logic [1:0]            dropped;
  } out_t;

  // one queued input event: type, keycode, value
  typedef struct packed {
    logic              ev_type;
    logic [CODE_W-1:0] ev_code;
    logic              ev_pressed;
  } evt_t;

  typedef struct packed {
    logic [1:0]        op;
    evt_t              evt;
    logic [TIME_W-1:0] time_ns;
  } cmd_t;

  typedef struct packed {
    evt_t              evt;
    logic [TIME_W-1:0] time_ns;
  } qent_t;

  // set 1 scancode to keycode; zero means unmapped
  function automatic logic [CODE_W-1:0] map_code(input logic [CODE_W-1:0] sc,
                                                 input logic ext);
    logic [CODE_W-1:0] k;
    k = '0;
    if (ext) begin
      case (sc)
        7'h1C: k = 7'd96;
        7'h1D: k = 7'd97;
        7'h35: k = 7'd98;
        7'h38: k = 7'd100;
        7'h47: k = 7'd102;
        7'h48: k = 7'd103;
        7'h49: k = 7'd104;
        7'h4B: k = 7'd105;
        7'h4D: k = 7'd106;
        7'h4F: k = 7'd107;
        7'h50: k = 7'd108;
        7'h51: k = 7'd109;
        7'h52: k = 7'd110;
        7'h53: k = 7'd111;
        default: k = '0;
      endcase
    end else if ((sc >= 7'd1 && sc <= 7'd83) || sc == 7'd87 || sc == 7'd88) begin
      k = sc;
    end
    return k;
  endfunction

  function automatic logic is_modifier(input logic [CODE_W-1:0] k);
    return k == 7'd42 || k == 7'd54 || k == 7'd29 || k == 7'd97 || k == 7'd56 ||
           k == 7'd100 || k == 7'd58 || k == 7'd69 || k == 7'd70;
  endfunction

endpackage
`default_nettype wire

/* rtl/sckq_front.sv */
// Front end: takes request beats, maps scancodes and issues queue commands.
`default_nettype none
module sckq_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic           cfg_wr_data,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sckq_pkg::in_t  in_data,
  input  wire logic           cmdq_full,
  output logic                cmd_push,
  output sckq_pkg::cmd_t      cmd
);
  import sckq_pkg::*;

  logic              listening_r;
  logic              listening_nxt;
  logic [CODE_W-1:0] key;
  logic              press;

  assign listening_nxt = cfg_wr_en ? cfg_wr_data : listening_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listening_r <= 1'b0;
    end else begin
      listening_r <= listening_nxt;
    end
  end

  assign in_ready = !cmdq_full;
  assign cmd_push = in_valid && in_ready;

  assign key   = map_code(in_data.scancode, in_data.extended);
  assign press = !in_data.released;

  always_comb begin
    cmd.op             = OP_NOP;
    cmd.evt.ev_type    = 1'b1;
    cmd.evt.ev_code    = key;
    cmd.evt.ev_pressed = press;
    cmd.time_ns        = in_data.time_ns;
    case (in_data.req_type)
      REQ_KEY: begin
        // drop unmapped codes, releases of ordinary keys, and every key beat while listening is clear
        if (listening_r && key != '0 && (press || is_modifier(key))) begin
          cmd.op = OP_KEY;
        end
      end
      REQ_READ:  cmd.op = OP_READ;
      REQ_FLUSH: cmd.op = OP_FLUSH;
      default:   cmd.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/sckq_cmdq.sv */
// Two-entry command queue between the front end and the queue engine.
`default_nettype none
module sckq_cmdq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sckq_pkg::cmd_t  push_cmd,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output sckq_pkg::cmd_t       head
);
  import sckq_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign head    = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* rtl/sckq_back.sv */
// Queue engine: ring buffer of events, executes commands, drives the result register.
`default_nettype none
module sckq_back #(
  parameter int QUEUE_DEPTH = sckq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  input  wire sckq_pkg::cmd_t  cmd,
  output logic                 cmd_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sckq_pkg::out_t       out_data
);
  import sckq_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SYNC  = 2'd1;
  localparam logic [1:0] ST_RDATA = 2'd2;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  qent_t             mem [QUEUE_DEPTH];
  qent_t             rdata_r;
  qent_t             mem_wdata;
  logic              mem_we, mem_re;

  logic [1:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              lost_r, lost_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r;
  out_t              res;
  logic              load;
  logic              full, out_free;

  assign full     = fill_r == FILL_MAX;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    lost_nxt   = lost_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata.evt     = cmd.evt;
    mem_wdata.time_ns = cmd.time_ns;
    load       = 1'b0;
    cmd_pop    = 1'b0;
    res        = '0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_KEY: begin
              // key event first; a full queue loses it
              if (!full) begin
                mem_we     = 1'b1;
                wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
                fill_nxt   = fill_r + 1'b1;
              end
              lost_nxt  = full;
              state_nxt = ST_SYNC;
            end
            OP_READ: begin
              if (fill_r != '0) begin
                mem_re     = 1'b1;
                rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
                fill_nxt   = fill_r - 1'b1;
                state_nxt  = ST_RDATA;
              end else if (out_free) begin
                load    = 1'b1;
                cmd_pop = 1'b1;
              end
            end
            OP_FLUSH: begin
              if (out_free) begin
                rd_ptr_nxt = '0;
                wr_ptr_nxt = '0;
                fill_nxt   = '0;
                load       = 1'b1;
                cmd_pop    = 1'b1;
              end
            end
            default: begin
              if (out_free) begin
                load    = 1'b1;
                cmd_pop = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SYNC: begin
        if (out_free) begin
          // sync report follows the key event; may be lost on its own
          mem_wdata.evt = '0;
          if (!full) begin
            mem_we     = 1'b1;
            wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
            fill_nxt   = fill_r + 1'b1;
          end
          res.dropped = {1'b0, lost_r} + {1'b0, full};
          load        = 1'b1;
          cmd_pop     = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_RDATA: begin
        if (out_free) begin
          res.event_valid   = 1'b1;
          res.event_type    = rdata_r.evt.ev_type;
          res.event_code    = rdata_r.evt.ev_code;
          res.event_value   = rdata_r.evt.ev_pressed;
          res.event_time_ns = rdata_r.time_ns;
          load              = 1'b1;
          cmd_pop           = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    res.events_pending = EVT_PEND_W'(fill_nxt);
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      lost_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      lost_r      <= lost_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* rtl/scancode_to_keycode_event_queue.sv */
// Top level of the PS/2 set 1 scancode to keycode event queue.
`default_nettype none
// Each input beat is a request: a key event (set 1 scancode, 0xE0 flag,
// press or release, timestamp), a read of one queued event, or a flush.
// Key beats are mapped to keycodes in the front end (identity for 1..83,
// 87 and 88 for F11/F12, the fourteen extended codes to 96..111); unmapped
// codes, releases of non-modifier keys, and all key beats while listening
// is clear are answered without touching the queue. An accepted key pushes
// a key event and then a sync report into a ring buffer of QUEUE_DEPTH
// entries; each push that finds the buffer full is lost and counted in
// dropped. Every request beat yields exactly one result beat, carrying the
// popped event for a successful read and the fill level after the request.
// Timing: a two-entry command queue sits between front end and queue
// engine, so another request can enter while a result waits on out_ready.
// A key beat runs ST_IDLE then ST_SYNC (two writes through the single
// write port of the event memory), a non-empty read ST_IDLE then ST_RDATA
// (registered memory read), anything else ST_IDLE alone. The listening bit
// is set through cfg_wr_en / cfg_wr_data, takes effect on the next cycle,
// and does not flush the queue. The buffer needs no clearing after reset.
module scancode_to_keycode_event_queue #(
  parameter int QUEUE_DEPTH = sckq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_wr_data,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sckq_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sckq_pkg::out_t       out_data
);
  import sckq_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_push;
  logic cmd_pop;
  logic cmdq_full;
  logic cmdq_empty;

  // classify the request and hold the listening bit
  sckq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cmdq_full   (cmdq_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  // decouple the two sides
  sckq_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (cmd_pop),
    .full     (cmdq_full),
    .empty    (cmdq_empty),
    .head     (cmd_head)
  );

  // carry out the command against the event ring and emit the result beat
  sckq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmdq_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* verif/scancode_to_keycode_event_queue_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the scancode to keycode event queue.
module scancode_to_keycode_event_queue_tb;
  import sckq_pkg::*;

  localparam int DEPTH        = QUEUE_DEPTH_DEF;
  localparam int RANDOM_BEATS = 1850;
  localparam int SEG_BEATS    = 40;
  localparam int SETTLE       = 8;

  // request code that the block must treat as a no-op
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // traffic mixes for one random segment
  localparam int MIX_BURST = 0;
  localparam int MIX_KEYS  = 1;
  localparam int MIX_EVEN  = 2;
  localparam int MIX_READS = 3;

  // extended (0xE0) scancodes and the keycodes they stand for
  localparam logic [6:0] EXT_SCAN [14] = '{7'h1C, 7'h1D, 7'h35, 7'h38, 7'h47, 7'h48, 7'h49,
                                           7'h4B, 7'h4D, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53};
  localparam logic [6:0] EXT_KEY  [14] = '{7'd96, 7'd97, 7'd98, 7'd100, 7'd102, 7'd103,
                                           7'd104, 7'd105, 7'd106, 7'd107, 7'd108, 7'd109,
                                           7'd110, 7'd111};
  // keycodes whose release is reported (shift, ctrl, alt, caps/num/scroll lock)
  localparam logic [6:0] MOD_KEYS [9] = '{7'd29, 7'd42, 7'd54, 7'd56, 7'd58, 7'd69, 7'd70,
                                          7'd97, 7'd100};

  logic clk         = 1'b0;
  logic rst_n       = 1'b0;
  logic cfg_wr_en   = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid    = 1'b0;
  logic in_ready;
  in_t  in_data     = '0;
  logic out_valid;
  logic out_ready   = 1'b0;
  out_t out_data;

  // idling controls, changed per phase
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int error_count     = 0;

  // shadow of the event ring and the listening bit
  evt_t        ring_evt  [DEPTH];
  logic [63:0] ring_time [DEPTH];
  int          rd_idx    = 0;
  int          wr_idx    = 0;
  int          fill_lvl  = 0;
  logic        listen_en = 1'b0;

  // replies predicted for accepted requests, oldest first
  out_t expected_replies [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  scancode_to_keycode_event_queue dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Translate a set 1 scancode; zero means no keycode exists for it.
  function automatic logic [6:0] keycode_of(logic [6:0] sc, logic ext);
    logic [6:0] kc;
    kc = '0;
    if (ext) begin
      foreach (EXT_SCAN[i])
        if (EXT_SCAN[i] == sc) kc = EXT_KEY[i];
    end else if ((sc >= 7'd1 && sc <= 7'd83) || sc == 7'd87 || sc == 7'd88) begin
      kc = sc;
    end
    return kc;
  endfunction

  function automatic bit is_modifier_key(logic [6:0] kc);
    bit hit;
    hit = 1'b0;
    foreach (MOD_KEYS[i])
      if (MOD_KEYS[i] == kc) hit = 1'b1;
    return hit;
  endfunction

  // Append one event to the shadow ring; return 1 when it is lost to a full ring.
  function automatic logic [1:0] ring_push(evt_t ev, logic [63:0] stamp);
    if (fill_lvl >= DEPTH) return 2'd1;
    ring_evt[wr_idx]  = ev;
    ring_time[wr_idx] = stamp;
    wr_idx   = (wr_idx + 1) % DEPTH;
    fill_lvl = fill_lvl + 1;
    return 2'd0;
  endfunction

  // Advance the shadow state by one request and return the reply it must give.
  function automatic out_t predict_reply(in_t beat);
    out_t       r;
    evt_t       ev;
    logic [6:0] kc;
    logic [1:0] lost;
    r    = '0;
    lost = 2'd0;
    case (beat.req_type)
      REQ_KEY: begin
        kc = keycode_of(beat.scancode, beat.extended);
        if (listen_en && kc != 7'd0 && (!beat.released || is_modifier_key(kc))) begin
          ev.ev_type    = 1'b1;
          ev.ev_code    = kc;
          ev.ev_pressed = !beat.released;
          lost = lost + ring_push(ev, beat.time_ns);
          // the sync report follows its key and may be the only one lost
          lost = lost + ring_push('0, beat.time_ns);
        end
      end
      REQ_READ: begin
        if (fill_lvl != 0) begin
          r.event_valid   = 1'b1;
          r.event_type    = ring_evt[rd_idx].ev_type;
          r.event_code    = ring_evt[rd_idx].ev_code;
          r.event_value   = ring_evt[rd_idx].ev_pressed;
          r.event_time_ns = ring_time[rd_idx];
          rd_idx   = (rd_idx + 1) % DEPTH;
          fill_lvl = fill_lvl - 1;
        end
      end
      REQ_FLUSH: begin
        rd_idx   = 0;
        wr_idx   = 0;
        fill_lvl = 0;
      end
      default: ;
    endcase
    r.events_pending = 7'(fill_lvl);
    r.dropped        = lost;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: compare each accepted reply beat with the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        error_count++;
        $display("%0t: reply beat with none outstanding, expected nothing, got %p",
                 $time, out_data);
      end else begin
        want = expected_replies.pop_front();
        check_field("event_valid", want.event_valid, out_data.event_valid);
        check_field("event_type", want.event_type, out_data.event_type);
        check_field("event_code", want.event_code, out_data.event_code);
        check_field("event_value", want.event_value, out_data.event_value);
        check_field("event_time_ns", want.event_time_ns, out_data.event_time_ns);
        check_field("events_pending", want.events_pending, out_data.events_pending);
        check_field("dropped", want.dropped, out_data.dropped);
      end
    end
    // stall the reply channel at the rate of the current phase
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_t make_beat(logic [1:0] req, logic [6:0] sc, logic ext, logic rel,
                                    logic [63:0] stamp);
    in_t b;
    b.req_type = req;
    b.scancode = sc;
    b.extended = ext;
    b.released = rel;
    b.time_ns  = stamp;
    return b;
  endfunction

  // Build one random request; most key beats hit mapped codes so the ring fills.
  function automatic in_t random_beat(int key_pct, int read_pct);
    in_t        b;
    int         roll;
    logic [6:0] mk;
    b.scancode = 7'($urandom);
    b.extended = 1'($urandom);
    b.released = ($urandom_range(99) < 30);
    case ($urandom_range(19))
      0:       b.time_ns = '0;
      1:       b.time_ns = '1;
      default: b.time_ns = {$urandom, $urandom};
    endcase
    roll = $urandom_range(99);
    if (roll < key_pct) begin
      b.req_type = REQ_KEY;
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          b.scancode = EXT_SCAN[$urandom_range(13)];
          b.extended = 1'b1;
        end
        4, 5: begin
          // pick a modifier by keycode, then find its scancode
          mk = MOD_KEYS[$urandom_range(8)];
          b.extended = (mk == 7'd97 || mk == 7'd100);
          b.scancode = (mk == 7'd97) ? 7'h1D : (mk == 7'd100) ? 7'h38 : mk;
        end
        6, 7, 8: begin
          b.scancode = 7'($urandom_range(1, 88));
          b.extended = 1'b0;
        end
        default: ;
      endcase
    end else if (roll < key_pct + read_pct) begin
      b.req_type = REQ_READ;
    end else begin
      b.req_type = ($urandom_range(3) == 0) ? REQ_UNUSED : REQ_FLUSH;
    end
    return b;
  endfunction

  // Offer one beat, with a random gap first, and hold it until it is taken.
  task automatic send_beat(input in_t beat);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    expected_replies.push_back(predict_reply(beat));
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every reply is back and the engine is idle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the listening bit; the block must be idle.
  task automatic write_listening(input logic val);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    listen_en = val;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset listening is clear: a read of the empty ring, the unused code,
  // a flush of nothing, and a key beat that must be ignored.
  task automatic test_idle_requests();
    send_beat(make_beat(REQ_READ, 7'h00, 1'b0, 1'b0, '1));
    send_beat(make_beat(REQ_UNUSED, 7'h7F, 1'b1, 1'b1, '1));
    send_beat(make_beat(REQ_FLUSH, 7'h00, 1'b0, 1'b0, '0));
    send_beat(make_beat(REQ_KEY, 7'h1E, 1'b0, 1'b0, 64'h0123_4567_89AB_CDEF));
    wait_quiet();
  endtask

  // Table edges in both tables, unmapped codes and timestamp extremes.
  task automatic test_key_mapping();
    send_beat(make_beat(REQ_KEY, 7'd1, 1'b0, 1'b0, '0));
    send_beat(make_beat(REQ_KEY, 7'd83, 1'b0, 1'b0, '1));
    send_beat(make_beat(REQ_KEY, 7'd87, 1'b0, 1'b0, 64'h8000_0000_0000_0001));
    send_beat(make_beat(REQ_KEY, 7'd88, 1'b0, 1'b0, 64'h7FFF_FFFF_FFFF_FFFE));
    send_beat(make_beat(REQ_KEY, 7'd0, 1'b0, 1'b0, '1));
    send_beat(make_beat(REQ_KEY, 7'd84, 1'b0, 1'b0, '1));
    send_beat(make_beat(REQ_KEY, 7'h7F, 1'b0, 1'b0, '1));
    send_beat(make_beat(REQ_KEY, 7'h1C, 1'b1, 1'b0, 64'hDEAD_BEEF_0000_0001));
    send_beat(make_beat(REQ_KEY, 7'h53, 1'b1, 1'b0, 64'h0000_0001_DEAD_BEEF));
    send_beat(make_beat(REQ_KEY, 7'h1E, 1'b1, 1'b0, '1));
    send_beat(make_beat(REQ_KEY, 7'h7F, 1'b1, 1'b0, '1));
  endtask

  // Releases pass only for modifiers, in either table.
  task automatic test_release_filter();
    send_beat(make_beat(REQ_KEY, 7'h1E, 1'b0, 1'b1, 64'd10));
    send_beat(make_beat(REQ_KEY, 7'd42, 1'b0, 1'b1, 64'd11));
    send_beat(make_beat(REQ_KEY, 7'h1D, 1'b1, 1'b1, 64'd12));
    send_beat(make_beat(REQ_KEY, 7'd69, 1'b0, 1'b1, 64'd13));
  endtask

  // Pop a few events, flush the rest, then read the empty ring.
  task automatic test_read_and_flush();
    repeat (3) send_beat(make_beat(REQ_READ, 7'h55, 1'b1, 1'b1, '1));
    send_beat(make_beat(REQ_FLUSH, 7'h2A, 1'b1, 1'b0, '0));
    send_beat(make_beat(REQ_READ, 7'h00, 1'b0, 1'b0, '0));
    wait_quiet();
  endtask

  // Random segments under four idling phases. Burst segments drive the ring
  // past full so that whole pairs, and sync reports alone, get dropped.
  task automatic test_random_traffic();
    int segs;
    int mix;
    segs = (RANDOM_BEATS + 4 * SEG_BEATS - 1) / (4 * SEG_BEATS);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 78; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int s = 0; s < segs; s++) begin
        // configuration only changes with the block idle
        wait_quiet();
        write_listening($urandom_range(99) < 85);
        mix = $urandom_range(MIX_READS);
        repeat (SEG_BEATS) begin
          case (mix)
            MIX_BURST: send_beat(random_beat(92, 8));
            MIX_KEYS:  send_beat(random_beat(75, 23));
            MIX_EVEN:  send_beat(random_beat(50, 47));
            default:   send_beat(random_beat(25, 72));
          endcase
        end
      end
    end
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_requests();
    write_listening(1'b1);
    test_key_mapping();
    test_release_filter();
    test_read_and_flush();
    test_random_traffic();

    wait_quiet();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("scancode_to_keycode_event_queue_tb: done, clean");
    end else begin
      $display("scancode_to_keycode_event_queue_tb: done, errors");
    end
    $finish;
  end

  // Bound the run well beyond the slowest correct pass.
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d replies outstanding", $time, expected_replies.size());
    $display("scancode_to_keycode_event_queue_tb: done, errors");
    $finish;
  end

endmodule
